// ----- rtl/rrts_pkg.sv -----
// Shared types and constants of the round-robin task scheduler.
package rrts_pkg;

   localparam int MAX_TASKS_DEF = 256;

   localparam int TASK_W  = 8;
   localparam int BURST_W = 16;
   localparam int TIME_W  = 32;
   localparam int QUANT_W = 8;
   localparam int STAT_W  = 2;

   localparam int ID_SPACE = 1 << TASK_W;

   localparam logic [QUANT_W-1:0] QUANT_RESET = QUANT_W'(4);

   localparam logic OP_ARRIVAL = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   localparam logic [STAT_W-1:0] ST_QUEUED   = 2'd0;
   localparam logic [STAT_W-1:0] ST_REJECTED = 2'd1;
   localparam logic [STAT_W-1:0] ST_RAN      = 2'd2;
   localparam logic [STAT_W-1:0] ST_IDLE     = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_POP  = 3'b010,
      S_RUN  = 3'b100
   } state_type;

   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctl_type;

   typedef struct packed {
      logic               started;
      logic [BURST_W-1:0] remaining;
   } entry_type;

endpackage

// ----- rtl/rrts_fifo.sv -----
// Ready queue of task ids: one memory with head pointer and fill count.
module rrts_fifo #(
   parameter int MAX_TASKS = rrts_pkg::MAX_TASKS_DEF,
   parameter int AW        = $clog2(MAX_TASKS),
   parameter int CW        = $clog2(MAX_TASKS + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rrts_pkg::fifo_ctl_type      ctl,
   input  logic [rrts_pkg::TASK_W-1:0] push_id,
   output logic [rrts_pkg::TASK_W-1:0] pop_id,
   output logic [CW-1:0]               count
);

   logic [rrts_pkg::TASK_W-1:0] queue_ff [MAX_TASKS];
   logic [rrts_pkg::TASK_W-1:0] rd_ff;
   logic [AW-1:0]               head_ff, head_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [CW:0]                 tail_sum;
   logic [AW-1:0]               tail;

   // wrap the tail index at the queue depth
   always_comb begin
      tail_sum = (CW+1)'(head_ff) + (CW+1)'(count_ff);
      if (tail_sum >= (CW+1)'(MAX_TASKS)) begin
         tail_sum = tail_sum - (CW+1)'(MAX_TASKS);
      end
      tail = tail_sum[AW-1:0];
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (ctl.pop) begin
         head_in = (head_ff == AW'(MAX_TASKS - 1)) ? '0 : head_ff + 1'b1;
      end
      if (ctl.push && !ctl.pop) begin
         count_in = count_ff + 1'b1;
      end else if (!ctl.push && ctl.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         queue_ff[tail] <= push_id;
      end
      if (ctl.pop) begin
         rd_ff <= queue_ff[head_ff];
      end
   end

   assign pop_id = rd_ff;
   assign count  = count_ff;

endmodule

// ----- rtl/rrts_table.sv -----
// Per-id memory of remaining burst and started mark.
module rrts_table (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [rrts_pkg::TASK_W-1:0] wr_addr,
   input  rrts_pkg::entry_type         wr_data,
   input  logic                        rd_en,
   input  logic [rrts_pkg::TASK_W-1:0] rd_addr,
   output rrts_pkg::entry_type         rd_data
);

   rrts_pkg::entry_type entry_ff [rrts_pkg::ID_SPACE];
   rrts_pkg::entry_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= entry_ff[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

// ----- rtl/round_robin_task_scheduler_top.sv -----
// Top level of the round-robin task scheduler with its tick sequencer.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------------
//   req     | in        | req_valid / req_ready | operation, task_id, burst_length
//   rsp     | out       | rsp_valid / rsp_ready | status, running_task, first_run,
//           |           |                       | finished, now
//   csr     | in        | csr_valid / csr_ready | quantum
//
// An arrival request finishes in its accept cycle; its response is registered and shows in the next cycle.
// A tick request passes through S_RUN when the running task continues or the preempted task
// is the only one (one table read), through S_POP and then S_RUN when a task is popped (queue
// read, then table read), and answers from S_IDLE when the tick is idle; the memory reads set this.
// A new request is taken only once the previous response has been taken by rsp_ready.
// Reset clears the queue pointers, the running task, the slice and the time at once;
// the memories need no clearing pass, an arrival writes every entry before use.
module round_robin_task_scheduler_top #(
   parameter int MAX_TASKS = rrts_pkg::MAX_TASKS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_operation,
   input  logic [rrts_pkg::TASK_W-1:0]  req_task_id,
   input  logic [rrts_pkg::BURST_W-1:0] req_burst_length,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [rrts_pkg::STAT_W-1:0]  rsp_status,
   output logic [rrts_pkg::TASK_W-1:0]  rsp_running_task,
   output logic                         rsp_first_run,
   output logic                         rsp_finished,
   output logic [rrts_pkg::TIME_W-1:0]  rsp_now,
   // configuration channel
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [rrts_pkg::QUANT_W-1:0] csr_quantum
);

   localparam int CW = $clog2(MAX_TASKS + 1);

   rrts_pkg::state_type          state_ff, state_in;
   logic [rrts_pkg::TASK_W-1:0]  cur_task_ff, cur_task_in;
   logic                         cur_valid_ff, cur_valid_in;
   logic [rrts_pkg::QUANT_W-1:0] slice_ff, slice_in;
   logic [rrts_pkg::TIME_W-1:0]  time_ff, time_in;
   logic [rrts_pkg::QUANT_W-1:0] quantum_ff, quantum_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [rrts_pkg::STAT_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [rrts_pkg::TASK_W-1:0]  rsp_task_ff, rsp_task_in;
   logic                         rsp_first_ff, rsp_first_in;
   logic                         rsp_fin_ff, rsp_fin_in;
   logic [rrts_pkg::TIME_W-1:0]  rsp_now_ff, rsp_now_in;

   // queue and table hookup
   rrts_pkg::fifo_ctl_type       fifo_ctl;
   logic [rrts_pkg::TASK_W-1:0]  push_id;
   logic [rrts_pkg::TASK_W-1:0]  pop_id;
   logic [CW-1:0]                fifo_count;

   logic                         tbl_wr_en;
   logic [rrts_pkg::TASK_W-1:0]  tbl_wr_addr;
   rrts_pkg::entry_type          tbl_wr_data;
   logic                         tbl_rd_en;
   logic [rrts_pkg::TASK_W-1:0]  tbl_rd_addr;
   rrts_pkg::entry_type          tbl_rd_data;

   // per-request decode
   logic                         req_fire;
   logic [rrts_pkg::QUANT_W-1:0] quantum_eff;
   logic                         preempt;
   logic [CW:0]                  occupied;
   logic                         reject;
   logic [rrts_pkg::BURST_W-1:0] rem_next;

   assign req_ready = (state_ff == rrts_pkg::S_IDLE) && !rsp_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // a zero quantum acts as one
   assign quantum_eff = (quantum_ff == '0) ? rrts_pkg::QUANT_W'(1) : quantum_ff;
   assign preempt     = cur_valid_ff && (slice_ff >= quantum_eff);

   // keep one free slot so a preempted task always fits back in the queue
   assign occupied = (CW+1)'(fifo_count) + (CW+1)'(cur_valid_ff);
   assign reject   = (req_burst_length == '0) || (occupied >= (CW+1)'(MAX_TASKS));

   // lower the remaining burst, hold at zero for a shared entry already spent
   assign rem_next = tbl_rd_data.remaining
                   - rrts_pkg::BURST_W'(tbl_rd_data.remaining != '0);

   assign quantum_in = (csr_valid && csr_ready) ? csr_quantum : quantum_ff;

   always_comb begin
      state_in      = state_ff;
      cur_task_in   = cur_task_ff;
      cur_valid_in  = cur_valid_ff;
      slice_in      = slice_ff;
      time_in       = time_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_task_in   = rsp_task_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_fin_in    = rsp_fin_ff;
      rsp_now_in    = rsp_now_ff;
      fifo_ctl      = '0;
      push_id       = cur_task_ff;
      tbl_wr_en     = 1'b0;
      tbl_wr_addr   = req_task_id;
      tbl_wr_data   = '0;
      tbl_rd_en     = 1'b0;
      tbl_rd_addr   = cur_task_ff;

      case (state_ff)
         rrts_pkg::S_IDLE: begin
            if (req_fire && req_operation == rrts_pkg::OP_ARRIVAL) begin
               // queue the task and record its burst unless it is rejected; the time stands still
               rsp_valid_in  = 1'b1;
               rsp_task_in   = '0;
               rsp_first_in  = 1'b0;
               rsp_fin_in    = 1'b0;
               rsp_now_in    = time_ff;
               rsp_status_in = reject ? rrts_pkg::ST_REJECTED : rrts_pkg::ST_QUEUED;
               if (!reject) begin
                  tbl_wr_en         = 1'b1;
                  tbl_wr_addr       = req_task_id;
                  tbl_wr_data.started   = 1'b0;
                  tbl_wr_data.remaining = req_burst_length;
                  fifo_ctl.push     = 1'b1;
                  push_id           = req_task_id;
               end
            end else if (req_fire) begin
               time_in = time_ff + 1'b1;
               if (cur_valid_ff && !preempt) begin
                  // continue the running task
                  tbl_rd_en = 1'b1;
                  state_in  = rrts_pkg::S_RUN;
               end else if (preempt && fifo_count == '0) begin
                  // sole task: push and pop cancel, restart its slice
                  slice_in  = '0;
                  tbl_rd_en = 1'b1;
                  state_in  = rrts_pkg::S_RUN;
               end else if (fifo_count != '0) begin
                  // send back a preempted task and pop the head
                  fifo_ctl.push = preempt;
                  fifo_ctl.pop  = 1'b1;
                  cur_valid_in  = 1'b0;
                  state_in      = rrts_pkg::S_POP;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = rrts_pkg::ST_IDLE;
                  rsp_task_in   = '0;
                  rsp_first_in  = 1'b0;
                  rsp_fin_in    = 1'b0;
                  rsp_now_in    = time_in;
               end
            end
         end
         rrts_pkg::S_POP: begin
            // take the popped id and start its table read
            cur_task_in  = pop_id;
            cur_valid_in = 1'b1;
            slice_in     = '0;
            tbl_rd_en    = 1'b1;
            tbl_rd_addr  = pop_id;
            state_in     = rrts_pkg::S_RUN;
         end
         rrts_pkg::S_RUN: begin
            // run one unit and write the entry back
            tbl_wr_en             = 1'b1;
            tbl_wr_addr           = cur_task_ff;
            tbl_wr_data.started   = 1'b1;
            tbl_wr_data.remaining = rem_next;
            if (slice_ff != '1) begin
               slice_in = slice_ff + 1'b1;
            end
            if (rem_next == '0) begin
               cur_valid_in = 1'b0;
            end
            rsp_valid_in  = 1'b1;
            rsp_status_in = rrts_pkg::ST_RAN;
            rsp_task_in   = cur_task_ff;
            rsp_first_in  = !tbl_rd_data.started;
            rsp_fin_in    = (rem_next == '0);
            rsp_now_in    = time_ff;
            state_in      = rrts_pkg::S_IDLE;
         end
         default: begin
            state_in = rrts_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrts_pkg::S_IDLE;
         cur_task_ff  <= '0;
         cur_valid_ff <= 1'b0;
         slice_ff     <= '0;
         time_ff      <= '0;
         quantum_ff   <= rrts_pkg::QUANT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_task_ff  <= cur_task_in;
         cur_valid_ff <= cur_valid_in;
         slice_ff     <= slice_in;
         time_ff      <= time_in;
         quantum_ff   <= quantum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, held while the consumer stalls
   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_task_ff   <= rsp_task_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_fin_ff    <= rsp_fin_in;
      rsp_now_ff    <= rsp_now_in;
   end

   rrts_fifo #(
      .MAX_TASKS (MAX_TASKS)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .ctl     (fifo_ctl),
      .push_id (push_id),
      .pop_id  (pop_id),
      .count   (fifo_count)
   );

   rrts_table u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (tbl_rd_en),
      .rd_addr (tbl_rd_addr),
      .rd_data (tbl_rd_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_running_task = rsp_task_ff;
   assign rsp_first_run    = rsp_first_ff;
   assign rsp_finished     = rsp_fin_ff;
   assign rsp_now          = rsp_now_ff;

endmodule
